// ----- hdl/mcspg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcspg_pkg
// Shared types and defaults for the multi-channel servo pulse generator.
// ----------------------------------------------------------------------------
package mcspg_pkg;

  localparam int CHANNELS_DEF   = 24;
  localparam int WIDTH_BITS_DEF = 12;

  localparam int OP_BITS     = 2;
  localparam int CHAN_BITS   = 5;
  localparam int COUNT_BITS  = 16;
  localparam int GAP_BITS    = 16;

  localparam logic [GAP_BITS-1:0] GAP_TICKS_RESET = 16'd10000;

  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

endpackage

// ----- hdl/multi_channel_servo_pulse_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_generator
// Servo frame generator: stores per-channel pulse widths, runs a number of
// frames of pulse phase plus low gap, one result item per input item.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | operation, channel, width, frame_count
// out_    | output    | out_valid/out_stall| pins, running, frame_end, rejected
// cfg_    | input     | cfg_valid/cfg_ready| gap_ticks
//
// One item per cycle while the result is not stalled; each item passes the input register, then the result register.
// All per-item work is the channel comparators and the gap/tick counters.
// Synchronous active-low reset clears widths, counters and valids; gap_ticks
// returns to 10000. A stalled result holds; one more item is still taken into
// the input register behind it.
// ----------------------------------------------------------------------------
module multi_channel_servo_pulse_generator
  import mcspg_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_BITS-1:0]    in_operation,
  input  logic [CHAN_BITS-1:0]  in_channel,
  input  logic [WIDTH_BITS-1:0] in_width,
  input  logic [COUNT_BITS-1:0] in_frame_count,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHANNELS-1:0]   out_pins,
  output logic                  out_running,
  output logic                  out_frame_end,
  output logic                  out_rejected,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [GAP_BITS-1:0]   cfg_gap_ticks
);

  // input register
  logic                  s1_valid_r;
  logic [OP_BITS-1:0]    s1_op_r;
  logic [CHAN_BITS-1:0]  s1_chan_r;
  logic [WIDTH_BITS-1:0] s1_width_r;
  logic [COUNT_BITS-1:0] s1_count_r;

  // state
  logic [GAP_BITS-1:0]   gap_ticks_r;
  logic [WIDTH_BITS-1:0] pulse_tick_r, pulse_tick_nxt;
  logic [GAP_BITS-1:0]   gap_tick_r, gap_tick_nxt;
  logic [COUNT_BITS-1:0] frames_left_r, frames_left_nxt;
  logic                  in_gap_r, in_gap_nxt;

  // result register
  logic                  out_valid_r;
  logic [CHANNELS-1:0]   pins_r, pins_nxt;
  logic                  running_r;
  logic                  frame_end_r, frame_end_nxt;
  logic                  rejected_r, rejected_nxt;

  logic                  adv, fire, in_acc;
  logic                  wr_en;
  logic                  chan_ok;
  logic                  gap_now;
  logic [GAP_BITS-1:0]   gap_base;
  logic [GAP_BITS:0]     gap_done;
  logic [CHANNELS-1:0]   level;

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign chan_ok  = (int'(s1_chan_r) < CHANNELS);

  mcspg_width_bank #(
    .CHANNELS   (CHANNELS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en && fire),
    .wr_chan    (s1_chan_r),
    .wr_width   (s1_width_r),
    .pulse_tick (pulse_tick_r),
    .level      (level)
  );

  always_comb begin
    pulse_tick_nxt  = pulse_tick_r;
    gap_tick_nxt    = gap_tick_r;
    frames_left_nxt = frames_left_r;
    in_gap_nxt      = in_gap_r;
    pins_nxt        = '0;
    frame_end_nxt   = 1'b0;
    rejected_nxt    = 1'b0;
    wr_en           = 1'b0;
    gap_now         = in_gap_r;
    gap_base        = gap_tick_r;
    gap_done        = '0;
    case (op_t'(s1_op_r))
      OP_WRITE: begin
        if (frames_left_r != '0) begin
          rejected_nxt = 1'b1;
        end else if (chan_ok) begin
          wr_en = 1'b1;
        end
      end
      OP_START: begin
        frames_left_nxt = s1_count_r;
        pulse_tick_nxt  = '0;
        gap_tick_nxt    = '0;
        in_gap_nxt      = 1'b0;
      end
      OP_TICK: begin
        if (frames_left_r != '0) begin
          if (!in_gap_r) begin
            pins_nxt = level;
            if (|level) begin
              pulse_tick_nxt = pulse_tick_r + 1'b1;
            end else begin
              gap_now  = 1'b1;
              gap_base = '0;
            end
          end
          if (gap_now) begin
            gap_done = {1'b0, gap_base} + 1'b1;
            if (gap_done >= {1'b0, gap_ticks_r}) begin
              frame_end_nxt   = 1'b1;
              frames_left_nxt = frames_left_r - 1'b1;
              pulse_tick_nxt  = '0;
              gap_tick_nxt    = '0;
              in_gap_nxt      = 1'b0;
            end else begin
              gap_tick_nxt = gap_done[GAP_BITS-1:0];
              in_gap_nxt   = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      gap_ticks_r   <= GAP_TICKS_RESET;
      pulse_tick_r  <= '0;
      gap_tick_r    <= '0;
      frames_left_r <= '0;
      in_gap_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gap_ticks_r <= cfg_gap_ticks;
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fire) begin
        pulse_tick_r  <= pulse_tick_nxt;
        gap_tick_r    <= gap_tick_nxt;
        frames_left_r <= frames_left_nxt;
        in_gap_r      <= in_gap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_operation;
      s1_chan_r  <= in_channel;
      s1_width_r <= in_width;
      s1_count_r <= in_frame_count;
    end
    if (fire) begin
      pins_r      <= pins_nxt;
      running_r   <= (frames_left_nxt != '0);
      frame_end_r <= frame_end_nxt;
      rejected_r  <= rejected_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pins      = pins_r;
  assign out_running   = running_r;
  assign out_frame_end = frame_end_r;
  assign out_rejected  = rejected_r;

endmodule

// ----- hdl/mcspg_width_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcspg_width_bank
// Per-channel pulse width registers with one comparator per channel giving
// the pin levels for the current pulse tick.
// ----------------------------------------------------------------------------
module mcspg_width_bank
  import mcspg_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CHAN_BITS-1:0]  wr_chan,
  input  logic [WIDTH_BITS-1:0] wr_width,
  input  logic [WIDTH_BITS-1:0] pulse_tick,
  output logic [CHANNELS-1:0]   level
);

  logic [WIDTH_BITS-1:0] width_r [CHANNELS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (!rst_n) begin
        width_r[i] <= '0;
      end else if (wr_en && (int'(wr_chan) == i)) begin
        width_r[i] <= wr_width;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      level[i] = (width_r[i] > pulse_tick);
    end
  end

endmodule

// ----- verif/tb_multi_channel_servo_pulse_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_servo_pulse_generator
// Self-checking bench for the servo frame generator. A queue of commands
// (width writes, starts, microsecond ticks, spare codes) feeds a clocked
// driver with random gaps. Every accepted item updates a local frame model
// that predicts pins, running, frame end and reject. A clocked monitor with
// random stalls checks every result in order. The gap register is rewritten
// between phases with the generator drained.
// ----------------------------------------------------------------------------
module tb_multi_channel_servo_pulse_generator;
  import mcspg_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam int WB  = WIDTH_BITS_DEF;
  localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1230;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [CHAN_BITS-1:0]  channel;
    logic [WB-1:0]         width;
    logic [COUNT_BITS-1:0] frames;
  } servo_cmd_t;

  typedef struct packed {
    logic [NCH-1:0] pins;
    logic           running;
    logic           frame_end;
    logic           rejected;
  } servo_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_BITS-1:0]    in_operation = '0;
  logic [CHAN_BITS-1:0]  in_channel = '0;
  logic [WB-1:0]         in_width = '0;
  logic [COUNT_BITS-1:0] in_frame_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [NCH-1:0]        out_pins;
  logic                  out_running;
  logic                  out_frame_end;
  logic                  out_rejected;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [GAP_BITS-1:0]   cfg_gap_ticks = '0;

  multi_channel_servo_pulse_generator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_channel     (in_channel),
    .in_width       (in_width),
    .in_frame_count (in_frame_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pins       (out_pins),
    .out_running    (out_running),
    .out_frame_end  (out_frame_end),
    .out_rejected   (out_rejected),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_gap_ticks  (cfg_gap_ticks)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // frame model state
  logic [WB-1:0]         chan_width [NCH] = '{default: '0};
  logic [WB-1:0]         pulse_pos = '0;
  logic [GAP_BITS-1:0]   gap_pos = '0;
  logic [COUNT_BITS-1:0] frames_todo = '0;
  logic                  gap_phase = 1'b0;
  logic [GAP_BITS-1:0]   gap_len = GAP_TICKS_RESET;

  servo_cmd_t pending_cmds[$];
  servo_out_t expected_outs[$];
  servo_cmd_t cur_cmd;
  logic [2:0] send_wait = '0;
  logic [2:0] stall_left = '0;
  bit         send_gaps = 1'b1;
  bit         recv_gaps = 1'b1;
  int         cmds_queued = 0;
  int         cmds_sent = 0;
  int         frames_seen = 0;
  int         rejects_seen = 0;
  int         gap_writes = 0;
  int         mismatches = 0;

  task automatic predict_frame(input servo_cmd_t c);
    servo_out_t r;
    logic [NCH-1:0] lvl;
    logic [GAP_BITS:0] done;
    logic gap_now;
    r = '0;
    lvl = '0;
    case (c.op)
      OP_WRITE: begin
        if (frames_todo != 0) r.rejected = 1'b1;
        else if (c.channel < NCH) chan_width[c.channel] = c.width;
      end
      OP_START: begin
        frames_todo = c.frames;
        pulse_pos = '0;
        gap_pos = '0;
        gap_phase = 1'b0;
      end
      OP_TICK: begin
        if (frames_todo != 0) begin
          gap_now = gap_phase;
          if (!gap_now) begin
            for (int i = 0; i < NCH; i++) lvl[i] = chan_width[i] > pulse_pos;
            r.pins = lvl;
            if (lvl != 0) begin
              pulse_pos = pulse_pos + 1'b1;
            end else begin
              gap_now = 1'b1;
              gap_pos = '0;
            end
          end
          if (gap_now) begin
            done = {1'b0, gap_pos} + 1'b1;
            if (done >= {1'b0, gap_len}) begin
              r.frame_end = 1'b1;
              frames_todo = frames_todo - 1'b1;
              pulse_pos = '0;
              gap_pos = '0;
              gap_phase = 1'b0;
            end else begin
              gap_pos = done[GAP_BITS-1:0];
              gap_phase = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.running = (frames_todo != 0);
    expected_outs.push_back(r);
  endtask

  always @(posedge clk) begin : driver
    servo_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait <= '0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_frame(cur_cmd);
        cmds_sent++;
      end
      if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait <= send_wait - 1'b1;
      end else if (pending_cmds.size() != 0) begin
        nxt = pending_cmds.pop_front();
        cur_cmd <= nxt;
        in_operation <= nxt.op;
        in_channel <= nxt.channel;
        in_width <= nxt.width;
        in_frame_count <= nxt.frames;
        in_valid <= 1'b1;
        send_wait <= send_gaps ? 3'($urandom_range(0, 6)) : 3'd0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string what, input servo_out_t want,
                               input servo_out_t got);
    if (mismatches < 10)
      $display("%0t %s: exp pins=%h run=%b end=%b rej=%b, got pins=%h run=%b end=%b rej=%b",
               $realtime, what, want.pins, want.running, want.frame_end, want.rejected,
               got.pins, got.running, got.frame_end, got.rejected);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    servo_out_t got;
    servo_out_t want;
    int hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= '0;
    end else if (out_valid && !out_stall) begin
      got = {out_pins, out_running, out_frame_end, out_rejected};
      if (expected_outs.size() == 0) begin
        flag_mismatch("unexpected item", '0, got);
      end else begin
        want = expected_outs.pop_front();
        if (got !== want) flag_mismatch("mismatch", want, got);
      end
      if (got.frame_end === 1'b1) frames_seen++;
      if (got.rejected === 1'b1) rejects_seen++;
      hold = recv_gaps ? $urandom_range(0, 6) : 0;
      stall_left <= 3'(hold);
      out_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1'b1;
      out_stall <= (stall_left > 1);
    end
  end

  task automatic add_cmd(input logic [OP_BITS-1:0] op, input logic [CHAN_BITS-1:0] ch,
                         input logic [WB-1:0] w, input logic [COUNT_BITS-1:0] fc);
    servo_cmd_t c;
    c.op = op;
    c.channel = ch;
    c.width = w;
    c.frames = fc;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic add_write(input int ch, input int w);
    add_cmd(OP_WRITE, CHAN_BITS'(ch), WB'(w), COUNT_BITS'($urandom));
  endtask

  task automatic add_start(input int n);
    add_cmd(OP_START, CHAN_BITS'($urandom), WB'($urandom), COUNT_BITS'(n));
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_cmd(OP_TICK, CHAN_BITS'($urandom), WB'($urandom), COUNT_BITS'($urandom));
  endtask

  task automatic add_spare();
    add_cmd(OP_SPARE, CHAN_BITS'($urandom), WB'($urandom), COUNT_BITS'($urandom));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_outs.size() != 0);
  endtask

  task automatic write_gap(input logic [GAP_BITS-1:0] v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_gap_ticks <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_len = v;
    gap_writes++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset gap length: idle ticks, spare code, range and run edge cases
    add_ticks(1);
    add_cmd(OP_SPARE, '1, '1, '1);
    add_write(0, 4095);
    add_write(23, 2);
    add_write(31, 4095);
    add_write(24, 5);
    add_write(5, 3);
    add_start(0);
    add_ticks(1);
    add_cmd(OP_START, '0, '0, '1);
    add_write(1, 7);
    add_ticks(3);
    add_start(2);
    add_ticks(2);
    add_spare();
    add_start(0);
    add_write(0, 0);

    write_gap('0);
    add_start(2);
    add_ticks(8);

    // long gap, then shortened while the frame sits in it
    write_gap('1);
    add_start(1);
    add_ticks(6);
    write_gap(16'd2);
    add_ticks(1);
    add_write(5, 0);
    add_write(23, 0);
    add_start(1);
    add_ticks(2);

    while (cmds_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) write_gap('0);
      else if (pick == 1) write_gap('1);
      else if (pick == 2) write_gap(GAP_BITS'($urandom));
      else write_gap(GAP_BITS'($urandom_range(1, 12)));
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) add_write($urandom_range(0, 23), $urandom_range(0, 15));
      pick = $urandom_range(0, 9);
      if (pick == 0) add_start(0);
      else if (pick == 1) add_start($urandom_range(0, 65535));
      else add_start($urandom_range(1, 4));
      repeat (40) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) add_ticks(1);
        else if (pick < 84) add_write($urandom_range(0, 23), $urandom_range(0, 15));
        else if (pick < 89) add_write($urandom_range(24, 31), $urandom_range(0, 4095));
        else if (pick < 94) add_start($urandom_range(1, 3));
        else if (pick < 97) add_spare();
        else add_start(0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d items over %0d gap settings; saw %0d frame ends, %0d rejected writes.",
             cmds_sent, gap_writes, frames_seen, rejects_seen);
    if (mismatches == 0) begin
      $display("tb_multi_channel_servo_pulse_generator: clean");
    end else begin
      $display("tb_multi_channel_servo_pulse_generator: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_multi_channel_servo_pulse_generator: errors");
    $finish;
  end

endmodule

// ----- multi_channel_servo_pulse_generator.f -----
hdl/mcspg_pkg.sv
hdl/mcspg_width_bank.sv
hdl/multi_channel_servo_pulse_generator.sv
verif/tb_multi_channel_servo_pulse_generator.sv
